[hw/rtl/udec_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the front end, request queue and back end.
// ----------------------------------------------------------------------------
package udec_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CPW = 31;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [7:0] MASK_LEN2 = 8'b0001_1111;
  localparam logic [7:0] MASK_LEN3 = 8'b0000_1111;
  localparam logic [7:0] MASK_LEN4 = 8'b0000_0111;
  localparam logic [7:0] MASK_LEN5 = 8'b0000_0011;
  localparam logic [7:0] MASK_LEN6 = 8'b0000_0001;

  typedef enum logic [2:0] {
    OP_SINGLE,
    OP_BAD,
    OP_TRUNC,
    OP_START,
    OP_SHIFT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
  } req_t;

endpackage

[hw/rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder, legacy six-byte form
// A byte that completes a result passes through the request queue and then the back end result register.
// Throughput: one byte per cycle while the result side keeps taking results.
// A four-entry request queue lets input and result sides stall independently.
// Reset (synchronous, active high) clears sequence state, queue and result valid flag.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import udec_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     data_byte,
  input  logic           end_of_buffer,
  output logic           empty,
  input  logic           pop,
  output logic [CPW-1:0] code_point,
  output logic [1:0]     status,
  output logic           buffer_done
);

  logic           accept;
  req_t           front_req;
  req_t           q_head;
  logic           q_rd;
  logic           q_empty;
  logic [QCW-1:0] q_count;

  assign accept = push && !full;

  udec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .req           (front_req)
  );

  udec_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_req (front_req),
    .rd     (q_rd),
    .head   (q_head),
    .full   (full),
    .empty  (q_empty),
    .count  (q_count)
  );

  udec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .code_point  (code_point),
    .status      (status),
    .buffer_done (buffer_done)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QDEPTH))
    else $error("Request queue count exceeds its depth.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (code_point == '0))
    else $error("Error result carries a nonzero code point.");

  a_trunc_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_TRUNC) |-> buffer_done)
    else $error("Truncated result not marked as end of buffer.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(status)))
    else $error("Waiting result changed before it was taken.");
`endif

endmodule

[hw/rtl/udec_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Tracks sequence position and classifies each byte into a request.
// ----------------------------------------------------------------------------
module udec_front
  import udec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output req_t       req
);

  logic [2:0] bytes_remaining;
  logic [2:0] bytes_remaining_next;
  logic [2:0] lead_len;
  logic [7:0] lead_mask;
  logic       lead_bad;
  logic [2:0] dec_remaining;

  always_comb begin
    lead_bad  = 1'b0;
    lead_len  = 3'd1;
    lead_mask = 8'hFF;
    if (data_byte inside {[8'h00:8'hBF]}) begin
      lead_len  = 3'd1;
    end else if (data_byte inside {[8'hC0:8'hDF]}) begin
      lead_len  = 3'd2;
      lead_mask = MASK_LEN2;
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      lead_len  = 3'd3;
      lead_mask = MASK_LEN3;
    end else if (data_byte inside {[8'hF0:8'hF7]}) begin
      lead_len  = 3'd4;
      lead_mask = MASK_LEN4;
    end else if (data_byte inside {[8'hF8:8'hFB]}) begin
      lead_len  = 3'd5;
      lead_mask = MASK_LEN5;
    end else if (data_byte inside {[8'hFC:8'hFD]}) begin
      lead_len  = 3'd6;
      lead_mask = MASK_LEN6;
    end else begin
      lead_bad  = 1'b1;
    end
  end

  assign dec_remaining = bytes_remaining - 3'd1;

  always_comb begin
    req.data             = data_byte;
    req.last             = end_of_buffer;
    req.op               = OP_SHIFT;
    bytes_remaining_next = bytes_remaining;
    if (bytes_remaining == 3'd0) begin
      if (lead_bad) begin
        req.op = OP_BAD;
      end else if (lead_len == 3'd1) begin
        req.op = OP_SINGLE;
      end else if (end_of_buffer) begin
        req.op = OP_TRUNC;
      end else begin
        req.op               = OP_START;
        req.data             = data_byte & lead_mask;
        bytes_remaining_next = lead_len - 3'd1;
      end
    end else begin
      bytes_remaining_next = dec_remaining;
      if (dec_remaining == 3'd0) begin
        req.op = OP_FINISH;
      end else if (end_of_buffer) begin
        req.op = OP_TRUNC;
      end else begin
        req.op = OP_SHIFT;
      end
    end
    if (end_of_buffer) begin
      bytes_remaining_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 3'd0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

[hw/rtl/udec_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder request queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module udec_queue
  import udec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  req_t             wr_req,
  input  logic             rd,
  output req_t             head,
  output logic             full,
  output logic             empty,
  output logic [QCW-1:0]   count
);

  req_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (rd && !empty) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if ((wr && !full) && !(rd && !empty)) begin
        count <= count + QCW'(1);
      end else if (!(wr && !full) && (rd && !empty)) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

[hw/rtl/udec_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Executes requests on the accumulator and holds the result register.
// ----------------------------------------------------------------------------
module udec_back
  import udec_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  req_t           q_head,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output logic [CPW-1:0] code_point,
  output logic [1:0]     status,
  output logic           buffer_done
);

  logic [CPW-1:0] partial_value;
  logic           out_valid;
  logic           needs_out;
  logic           out_taken;
  logic [CPW-1:0] shifted;

  assign needs_out = (q_head.op != OP_START) && (q_head.op != OP_SHIFT);
  assign out_taken = pop && out_valid;
  assign q_rd      = !q_empty && (!needs_out || !out_valid || out_taken);
  assign shifted   = {partial_value[CPW-7:0], q_head.data[5:0]};
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      case (q_head.op)
        OP_START: begin
          partial_value <= CPW'(q_head.data);
        end
        OP_SHIFT: begin
          partial_value <= shifted;
        end
        default: begin
          partial_value <= partial_value;
        end
      endcase
      if (needs_out) begin
        buffer_done <= q_head.last;
        case (q_head.op)
          OP_SINGLE: begin
            code_point <= CPW'(q_head.data);
            status     <= ST_OK;
          end
          OP_FINISH: begin
            code_point <= shifted;
            status     <= ST_OK;
          end
          OP_TRUNC: begin
            code_point <= '0;
            status     <= ST_TRUNC;
          end
          default: begin
            code_point <= '0;
            status     <= ST_BAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd && needs_out) begin
      out_valid <= 1'b1;
    end else if (out_taken) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[tb/sv/tb_utf8_stream_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 stream decoder
// Bytes are sent through the push side and decoded code points are taken from
// the pop side. Each accepted byte runs through a local decoder model, and
// every popped result is checked against the oldest predicted code point.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
  import udec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [CPW-1:0] cp;
    logic [1:0]     st;
    logic           done;
  } decoded_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           push = 1'b0;
  logic           full;
  logic [7:0]     data_byte = 8'h00;
  logic           end_of_buffer = 1'b0;
  logic           empty;
  logic           pop = 1'b0;
  logic [CPW-1:0] code_point;
  logic [1:0]     status;
  logic           buffer_done;

  byte_req_t   pending_bytes[$];
  decoded_t    expected_cps[$];
  decoded_t    oldest_cp;
  byte_req_t   next_byte;
  logic [2:0]  seq_left = 3'd0;
  logic [30:0] seq_acc = 31'd0;
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 83;
  bit          failed = 1'b0;

  utf8_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .empty         (empty),
    .pop           (pop),
    .code_point    (code_point),
    .status        (status),
    .buffer_done   (buffer_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void emit_cp(input logic [30:0] cp, input logic [1:0] st,
                                  input logic done);
    decoded_t r;
    r.cp = cp;
    r.st = st;
    r.done = done;
    expected_cps.push_back(r);
    seq_left = 3'd0;
    seq_acc = 31'd0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    logic [30:0] pay;
    n = 0;
    pay = 31'd0;
    if (seq_left == 3'd0) begin
      if (!b[7] || b[7:6] == 2'b10) begin
        n = 1;
        pay = 31'(b);
      end else if (b[7:1] == 7'b1111110) begin
        n = 6;
        pay = 31'(b & MASK_LEN6);
      end else if (b[7:2] == 6'b111110) begin
        n = 5;
        pay = 31'(b & MASK_LEN5);
      end else if (b[7:3] == 5'b11110) begin
        n = 4;
        pay = 31'(b & MASK_LEN4);
      end else if (b[7:4] == 4'b1110) begin
        n = 3;
        pay = 31'(b & MASK_LEN3);
      end else if (b[7:5] == 3'b110) begin
        n = 2;
        pay = 31'(b & MASK_LEN2);
      end
      if (n == 0) begin
        emit_cp(31'd0, ST_BAD, last);
      end else if (n == 1) begin
        emit_cp(pay, ST_OK, last);
      end else if (last) begin
        emit_cp(31'd0, ST_TRUNC, 1'b1);
      end else begin
        seq_left = 3'(n - 1);
        seq_acc = pay;
      end
    end else begin
      seq_acc = {seq_acc[24:0], b[5:0]};
      seq_left = seq_left - 3'd1;
      if (seq_left == 3'd0) begin
        emit_cp(seq_acc, ST_OK, last);
      end else if (last) begin
        emit_cp(31'd0, ST_TRUNC, 1'b1);
      end
    end
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last);
    byte_req_t r;
    r.data = b;
    r.last = last;
    pending_bytes.push_back(r);
  endtask

  // Mostly well-formed sequences with random payload; some noise, invalid
  // leads, corrupted continuations and buffers cut inside a sequence.
  task automatic add_buffer();
    logic [7:0] buf_q[$];
    int unsigned nseq;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    nseq = $urandom_range(1, 4);
    for (int s = 0; s < nseq; s++) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        buf_q.push_back(8'($urandom));
      end else if (kind < 13) begin
        buf_q.push_back(8'hFE | 8'($urandom_range(1)));
      end else begin
        len = $urandom_range(1, 6);
        if (len == 1) begin
          buf_q.push_back(8'($urandom_range(0, 191)));
        end else begin
          buf_q.push_back((8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1))));
          for (int k = 1; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
              buf_q.push_back(8'($urandom));
            end else begin
              buf_q.push_back({2'b10, 6'($urandom)});
            end
          end
        end
      end
    end
    if (buf_q.size() > 1 && $urandom_range(4) == 0) begin
      cut = $urandom_range(1, buf_q.size() - 1);
      repeat (cut) void'(buf_q.pop_back());
    end
    foreach (buf_q[i]) add_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned target;
    target = pending_bytes.size() + count;
    while (pending_bytes.size() < target) add_buffer();
  endtask

  task automatic drain_requests();
    while (pending_bytes.size() != 0 || push) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(data_byte, end_of_buffer);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        data_byte <= next_byte.data;
        end_of_buffer <= next_byte.last;
        push <= 1'b1;
      end else begin
        data_byte <= 8'($urandom);
        end_of_buffer <= 1'($urandom);
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_cps.size() == 0) begin
          $error("unexpected result: code_point %h status %0d buffer_done %0b",
                 code_point, status, buffer_done);
          failed = 1'b1;
        end else begin
          oldest_cp = expected_cps.pop_front();
          if (code_point !== oldest_cp.cp) begin
            $error("code_point: expected %h, got %h", oldest_cp.cp, code_point);
            failed = 1'b1;
          end
          if (status !== oldest_cp.st) begin
            $error("status: expected %0d, got %0d", oldest_cp.st, status);
            failed = 1'b1;
          end
          if (buffer_done !== oldest_cp.done) begin
            $error("buffer_done: expected %0b, got %0b", oldest_cp.done, buffer_done);
            failed = 1'b1;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFD, 1'b0);
    repeat (4) add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_byte(8'hC0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFB, 1'b1);
    add_byte(8'hE0, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'hF0, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b1);
    add_random(130);
    drain_requests();

    send_idle_pct = 83;
    recv_idle_pct = 22;
    add_random(150);
    drain_requests();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(150);
    drain_requests();

    while (expected_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
